@@ rtl/srsw_pkg.sv @@
`timescale 1ns / 1ps
// srsw_pkg: shared types and constants for the selective-repeat sender window.
// No dependencies.
package srsw_pkg;

    localparam int MAX_PACKETS_DEF = 1024;
    localparam int MAX_WINDOW_DEF  = 32;

    localparam int IDX_W      = 10;   // packet index / total_packets
    localparam int SEQ_W      = 11;   // ack sequence number
    localparam int BASE_W     = 11;   // window base, scan pointer (reaches 1024)
    localparam int WIN_W      = 6;    // window_size register
    localparam int TIMER_W    = 8;    // retry timer / timeout_ticks
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    // input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ACK  = 1'b1;

    typedef struct packed {
        logic               acked;
        logic [TIMER_W-1:0] timer;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0]   total;
        logic [WIN_W-1:0]   window;
        logic [TIMER_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic              clearing;
        logic              finished;
        logic [BASE_W-1:0] base;
    } t_status;

endpackage

@@ rtl/srsw_mem.sv @@
`timescale 1ns / 1ps
// srsw_mem: per-packet entry store (acked flag + retry timer).
// One write port, one read port, registered read data. Uses srsw_pkg.
module srsw_mem
    import srsw_pkg::*;
#(
    parameter int DEPTH = MAX_PACKETS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/srsw_ctrl.sv @@
`timescale 1ns / 1ps
// srsw_ctrl: sequencer for clear pass, ack marking, base advance and tick scan.
// Drives the entry store read-modify-write and the output register. Uses srsw_pkg.
module srsw_ctrl
    import srsw_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int AW          = $clog2(MAX_PACKETS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_mode,
    input  logic [SEQ_W-1:0] i_ack_seq,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_send_index,
    output logic             o_last,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output t_entry           o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  t_entry           i_mem_rdata,
    output t_status          o_status
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ADV_REQ = 3'd2;
    localparam logic [2:0] ST_ADV_CHK = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_FLUSH   = 3'd5;

    localparam int SPAN_W = $clog2(MAX_WINDOW + 1) > WIN_W ?
                            $clog2(MAX_WINDOW + 1) : WIN_W;
    localparam int SUM_W  = BASE_W + 1;

    logic [2:0]        r_state,      n_state;
    logic [AW-1:0]     r_clr,        n_clr;
    logic [BASE_W-1:0] r_base,       n_base;
    logic              r_finished,   n_finished;
    logic [BASE_W-1:0] r_ptr,        n_ptr;
    logic [BASE_W-1:0] r_end,        n_end;
    logic              r_hold_valid, n_hold_valid;
    logic [IDX_W-1:0]  r_hold_index, n_hold_index;
    logic              r_out_valid,  n_out_valid;
    logic [IDX_W-1:0]  r_out_index,  n_out_index;
    logic              r_out_last,   n_out_last;

    logic              out_free;
    logic [SEQ_W-1:0]  ack_idx;
    logic [SPAN_W-1:0] span;
    logic [SUM_W-1:0]  win_sum;
    logic [SUM_W-1:0]  win_lim;
    logic [BASE_W-1:0] total_ext;
    logic [BASE_W-1:0] scan_start;
    logic [BASE_W-1:0] scan_stop;
    logic              due;
    logic [BASE_W-1:0] ptr_inc;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign total_ext = {1'b0, i_cfg.total};
    assign ack_idx   = i_ack_seq - SEQ_W'(1);
    assign ptr_inc   = r_ptr + BASE_W'(1);
    assign due       = !i_mem_rdata.acked && (i_mem_rdata.timer == '0);

    // scan range of a tick: data phase clips to window, data end and store depth;
    // terminator phase handles entry total_packets alone, if it is below MAX_PACKETS
    always_comb begin
        span = (32'(i_cfg.window) > MAX_WINDOW) ? SPAN_W'(MAX_WINDOW)
                                                : SPAN_W'(i_cfg.window);
        win_sum = SUM_W'(r_base) + SUM_W'(span);
        win_lim = (win_sum < SUM_W'(i_cfg.total)) ? win_sum : SUM_W'(i_cfg.total);
        if (32'(win_lim) > MAX_PACKETS) begin
            win_lim = SUM_W'(MAX_PACKETS);
        end
        if (r_base >= total_ext) begin
            scan_start = total_ext;
            scan_stop  = (32'(i_cfg.total) < MAX_PACKETS) ? total_ext + BASE_W'(1)
                                                          : total_ext;
        end else begin
            scan_start = r_base;
            scan_stop  = BASE_W'(win_lim);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_base       = r_base;
        n_finished   = r_finished;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_hold_valid = r_hold_valid;
        n_hold_index = r_hold_index;
        n_out_valid  = r_out_valid;
        n_out_index  = r_out_index;
        n_out_last   = r_out_last;
        o_mem_we     = 1'b0;
        o_mem_waddr  = AW'(r_ptr);
        o_mem_wdata  = '0;
        o_mem_raddr  = AW'(r_ptr);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(MAX_PACKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && !r_finished) begin
                    if (i_mode == MODE_ACK) begin
                        if (i_ack_seq == '0) begin
                            n_finished = 1'b1;
                        end else begin
                            if (ack_idx <= total_ext && 32'(ack_idx) < MAX_PACKETS) begin
                                o_mem_we          = 1'b1;
                                o_mem_waddr       = AW'(ack_idx);
                                o_mem_wdata.acked = 1'b1;
                            end
                            n_state = ST_ADV_REQ;
                        end
                    end else begin
                        n_ptr       = scan_start;
                        n_end       = scan_stop;
                        o_mem_raddr = AW'(scan_start);
                        if (scan_start < scan_stop) begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_ADV_REQ: begin
                o_mem_raddr = AW'(r_base);
                n_state     = ST_ADV_CHK;
            end
            ST_ADV_CHK: begin
                if (r_base <= total_ext && 32'(r_base) < MAX_PACKETS &&
                    i_mem_rdata.acked) begin
                    n_base      = r_base + BASE_W'(1);
                    o_mem_raddr = AW'(r_base + BASE_W'(1));
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // a new send request pushes the held one out; wait for room
                if (!(due && r_hold_valid && !out_free)) begin
                    if (!i_mem_rdata.acked) begin
                        o_mem_we          = 1'b1;
                        o_mem_wdata.timer = due ? i_cfg.timeout
                                                : i_mem_rdata.timer - TIMER_W'(1);
                    end
                    if (due) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_index = r_hold_index;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_index = IDX_W'(r_ptr);
                    end
                    n_ptr       = ptr_inc;
                    o_mem_raddr = AW'(ptr_inc);
                    if (ptr_inc == r_end) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_hold_index;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_base       <= '0;
            r_finished   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_base       <= n_base;
            r_finished   <= n_finished;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_end        <= n_end;
        r_hold_index <= n_hold_index;
        r_out_index  <= n_out_index;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_send_index      = r_out_index;
    assign o_last            = r_out_last;
    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.finished = r_finished;
    assign o_status.base     = r_base;

endmodule

@@ rtl/selective_repeat_sender_window.sv @@
`timescale 1ns / 1ps
// selective_repeat_sender_window: top level of the selective-repeat sender window.
// Holds configuration registers; instantiates srsw_ctrl and srsw_mem. Uses srsw_pkg.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_mode, i_ack_seq
//   output    out        o_out_valid / i_out_stall  o_send_index, o_last
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Ticks: a tick scans N entries, up to the window size (capped at MAX_WINDOW),
// one entry per cycle while the output does not stall it, then flushes its held
// request, if any. An ack marks its entry, then the base moves past acked entries.
// Reset: a clearing pass writes every store entry with o_in_stall high;
// configuration writes are taken meanwhile.
// Stalls: output stall holds the scan when a send request finds the hold and
// output registers both full, and holds the end of a tick until its last
// request is in the output register; that one can wait while the next scans.
module selective_repeat_sender_window
    import srsw_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [SEQ_W-1:0]      i_ack_seq,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_send_index,
    output logic                  o_last
);

    localparam int AW = $clog2(MAX_PACKETS);

    t_cfg          r_cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    t_status       status;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total   <= IDX_W'(0);
            r_cfg.window  <= WIN_W'(4);
            r_cfg.timeout <= TIMER_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TOTAL:   r_cfg.total   <= i_cfg_data[IDX_W-1:0];
                REG_WINDOW:  r_cfg.window  <= i_cfg_data[WIN_W-1:0];
                REG_TIMEOUT: r_cfg.timeout <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    srsw_ctrl #(
        .MAX_PACKETS (MAX_PACKETS),
        .MAX_WINDOW  (MAX_WINDOW),
        .AW          (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_ack_seq    (i_ack_seq),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_send_index (o_send_index),
        .o_last       (o_last),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_status     (status)
    );

    srsw_mem #(
        .DEPTH (MAX_PACKETS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // once finished, stays finished until reset
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.finished |=> status.finished)
        else $error("finished flag dropped without reset");

    // the window base only moves forward
    a_base_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (status.base >= $past(status.base)))
        else $error("window base moved backward");

    // no transaction is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !status.clearing)
        else $error("input accepted during clearing pass");

endmodule
